[src/grc_pkg.sv]
// Shared constants, codes and helper functions for the grid ray caster.
package grc_pkg;

  // Default geometry, handed to the top level parameters
  localparam int MAP_SIDE_DEF   = 8;
  localparam int MAX_STEPS_DEF  = 8;
  localparam int CELL_SHIFT_DEF = 6;

  // Field widths
  localparam int CELL_IDX_W = 6;
  localparam int CODE_W     = 3;
  localparam int PX_W       = 17;
  localparam int ANG_W      = 12;
  localparam int DIST_W     = 18;
  localparam int COORD_W    = 19;

  // Number of cells a write can address
  localparam int WR_CELLS = 2 ** CELL_IDX_W;

  // Fixed point
  localparam int FRAC_BITS = 8;
  localparam int TRIG_FRAC = 14;
  localparam int TAN_FRAC  = 12;
  localparam int TRIG_W    = 16;
  localparam int NEAR_ZERO = 16;
  localparam int TRIG_ONE  = 16384;

  // Internal datapath widths
  localparam int POS_W  = 40;
  localparam int MB_W   = 24;
  localparam int PROD_W = POS_W + MB_W;
  localparam int POLY_W = 24;
  localparam int TAN_W  = MB_W;
  localparam int DEN_W  = 15;
  localparam int DIV_W  = DEN_W + TAN_FRAC;

  // Saturation limits
  localparam int DIST_MAX  = 262143;
  localparam int COORD_MAX = 262143;
  localparam int COORD_MIN = -262144;

  // Request codes
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_CAST  = 1'b1;

  // Sine polynomial, Q20 coefficients, highest order first
  localparam logic signed [POLY_W-1:0] POLY_SEED = 24'sd168;

  function automatic logic signed [POLY_W-1:0] poly_coef(input logic [1:0] k);
    logic signed [POLY_W-1:0] c;
    case (k)
      2'd0:    c = -24'sd4909;
      2'd1:    c = 24'sd83564;
      2'd2:    c = -24'sd677343;
      default: c = 24'sd1647099;
    endcase
    return c;
  endfunction

  function automatic logic [DIST_W-1:0] sat_dist(input logic signed [POS_W-1:0] v);
    logic [DIST_W-1:0] r;
    if (v < 0) r = '0;
    else if (v > POS_W'(DIST_MAX)) r = DIST_W'(DIST_MAX);
    else r = v[DIST_W-1:0];
    return r;
  endfunction

  function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [POS_W-1:0] v);
    logic signed [COORD_W-1:0] r;
    if (v > POS_W'(COORD_MAX)) r = COORD_W'(COORD_MAX);
    else if (v < POS_W'(COORD_MIN)) r = COORD_W'(COORD_MIN);
    else r = v[COORD_W-1:0];
    return r;
  endfunction

endpackage

[src/grc_if.sv]
// Request and result channel interfaces of the grid ray caster.
interface grc_req_if;
  logic                              valid;
  logic                              ready;
  logic                              req_type;
  logic [grc_pkg::CELL_IDX_W-1:0]    cell_index;
  logic [grc_pkg::CODE_W-1:0]        cell_code;
  logic [grc_pkg::PX_W-1:0]          player_x;
  logic [grc_pkg::PX_W-1:0]          player_y;
  logic [grc_pkg::ANG_W-1:0]         ray_angle;

  modport source (output valid, req_type, cell_index, cell_code, player_x, player_y,
                  ray_angle, input ready);
  modport sink   (input valid, req_type, cell_index, cell_code, player_x, player_y,
                  ray_angle, output ready);
endinterface

interface grc_res_if;
  logic                              valid;
  logic                              ready;
  logic [grc_pkg::DIST_W-1:0]        hit_distance;
  logic signed [grc_pkg::COORD_W-1:0] hit_x;
  logic signed [grc_pkg::COORD_W-1:0] hit_y;
  logic [grc_pkg::CODE_W-1:0]        wall_type;
  logic                              vertical_side;
  logic                              no_hit;

  modport source (output valid, hit_distance, hit_x, hit_y, wall_type, vertical_side,
                  no_hit, input ready);
  modport sink   (input valid, hit_distance, hit_x, hit_y, wall_type, vertical_side,
                  no_hit, output ready);
endinterface

[src/grc_ram.sv]
// Generic single write, single read RAM with registered read data.
module grc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[src/grc_div.sv]
// Bit-serial restoring divider, one quotient bit per cycle.
module grc_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [grc_pkg::DIV_W-1:0]   dividend_i,
  input  logic [grc_pkg::DEN_W-1:0]   divisor_i,
  output logic                        done_o,
  output logic [grc_pkg::DIV_W-1:0]   quotient_o
);

  localparam int CntW = $clog2(grc_pkg::DIV_W + 1);

  logic                       busy_q;
  logic                       done_q;
  logic [CntW-1:0]            cnt_q;
  logic [grc_pkg::DIV_W-1:0]  quo_q;
  logic [grc_pkg::DEN_W-1:0]  rem_q;
  logic [grc_pkg::DEN_W-1:0]  den_q;
  logic [grc_pkg::DEN_W:0]    shift_rem;
  logic [grc_pkg::DEN_W:0]    trial;
  logic                       fits;

  // Trial subtract of the divisor from the shifted remainder
  always_comb begin
    shift_rem = {rem_q, quo_q[grc_pkg::DIV_W-1]};
    trial     = shift_rem - {1'b0, den_q};
    fits      = shift_rem >= {1'b0, den_q};
  end

  // Iterate over all dividend bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      quo_q  <= '0;
      rem_q  <= '0;
      den_q  <= '0;
    end else begin
      if (start_i) begin
        busy_q <= 1'b1;
        done_q <= 1'b0;
        cnt_q  <= CntW'(grc_pkg::DIV_W);
        quo_q  <= dividend_i;
        rem_q  <= '0;
        den_q  <= divisor_i;
      end else if (busy_q) begin
        quo_q  <= {quo_q[grc_pkg::DIV_W-2:0], fits};
        rem_q  <= fits ? trial[grc_pkg::DEN_W-1:0] : shift_rem[grc_pkg::DEN_W-1:0];
        cnt_q  <= cnt_q - 1'b1;
        busy_q <= (cnt_q != CntW'(1));
        done_q <= (cnt_q == CntW'(1));
      end else begin
        done_q <= 1'b0;
      end
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

[src/grid_ray_cast.sv]
// Grid ray caster top level: map store, sequencer and shared multiplier.
//
//  channel | dir | transfers              | payload
//  --------+-----+------------------------+---------------------------------------------
//  req_i   | in  | one map write or cast  | req_type, cell_index, cell_code, position, angle
//  res_o   | out | one result per cast    | hit_distance, hit_x, hit_y, wall_type, flags
//
//  A cast runs two sine evaluations on the shared multiplier, up to two bit-serial divisions,
//  then each walk does a map read per in-map cell it visits, plus setup and distance.
//  Reset empties the map at once through per-cell valid flags; no clearing pass.
//  A finished result sits in the output register; the next request is taken while it waits,
//  and the sequencer only stalls when a new result is ready before the old one is taken.
module grid_ray_cast #(
  parameter int MAP_SIDE   = grc_pkg::MAP_SIDE_DEF,
  parameter int MAX_STEPS  = grc_pkg::MAX_STEPS_DEF,
  parameter int CELL_SHIFT = grc_pkg::CELL_SHIFT_DEF
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  grc_req_if.sink   req_i,
  grc_res_if.source res_o
);

  localparam int CellW    = grc_pkg::FRAC_BITS + CELL_SHIFT;
  localparam int NCells   = MAP_SIDE * MAP_SIDE;
  localparam int MemDepth = (NCells < grc_pkg::WR_CELLS) ? NCells : grc_pkg::WR_CELLS;
  localparam int MemAw    = $clog2(MemDepth);
  localparam int SideW    = $clog2(MAP_SIDE);
  localparam int MpW      = $clog2(NCells + 1);
  localparam int StepW    = $clog2(MAX_STEPS + 1);
  localparam logic signed [grc_pkg::POS_W-1:0] CellSpan =
    grc_pkg::POS_W'(longint'(1) << CellW);

  typedef enum logic [4:0] {
    S_IDLE, S_SQ_ISSUE, S_SQ_TAKE, S_PL_ISSUE, S_PL_TAKE, S_PT_ISSUE, S_PT_TAKE,
    S_DIV_T, S_DIV_T_WAIT, S_DIV_C, S_DIV_C_WAIT, S_WINIT, S_WM1, S_WM1T, S_WM2, S_WM2T,
    S_WALK, S_WREAD, S_D1, S_D1T, S_D2, S_D2T, S_WDONE, S_OUT
  } state_e;

  state_e state_q;

  // Request holding registers
  logic [grc_pkg::PX_W-1:0]  px_q, py_q;
  logic [grc_pkg::ANG_W-1:0] ang_q;

  // Trig and ratio registers
  logic                               which_q;
  logic [1:0]                         k_q;
  logic [16:0]                        t2_q;
  logic signed [grc_pkg::POLY_W-1:0]  p_q;
  logic signed [grc_pkg::TRIG_W-1:0]  sin_q, cos_q;
  logic signed [grc_pkg::TAN_W-1:0]   tn_q, ct_q;

  // Walk registers
  logic                               dir_q;
  logic signed [grc_pkg::POS_W-1:0]   rx_q, ry_q, xo_q, yo_q;
  logic [StepW-1:0]                   step_q;
  logic signed [grc_pkg::PROD_W-1:0]  d1_q;
  logic [grc_pkg::CODE_W-1:0]         code_q;
  logic                               vhit_q, hhit_q;
  logic [grc_pkg::CODE_W-1:0]         vcode_q, hcode_q;
  logic signed [grc_pkg::POS_W-1:0]   vx_q, vy_q, vdist_q, hx_q, hy_q, hdist_q;

  // Output register
  logic                               out_vld_q, out_vld_d;
  logic [grc_pkg::DIST_W-1:0]         out_dist_q;
  logic signed [grc_pkg::COORD_W-1:0] out_x_q, out_y_q;
  logic [grc_pkg::CODE_W-1:0]         out_wall_q;
  logic                               out_vside_q, out_nohit_q;

  // Multiplier
  logic signed [grc_pkg::POS_W-1:0]   mul_a;
  logic signed [grc_pkg::MB_W-1:0]    mul_b;
  logic signed [grc_pkg::PROD_W-1:0]  prod_d, prod_q;

  // Misc datapath
  logic signed [grc_pkg::POS_W-1:0]   px_s, py_s, bx, by;
  logic [grc_pkg::ANG_W-1:0]          a_cur;
  logic [10:0]                        qarg;
  logic [16:0]                        t_val;
  logic signed [grc_pkg::PROD_W-1:0]  pfin;
  logic signed [grc_pkg::TRIG_W-1:0]  trig_mag;
  logic signed [grc_pkg::TRIG_W-1:0]  sin_abs, cos_abs;
  logic                               c_pos, c_neg, s_pos, s_neg;
  logic signed [grc_pkg::PROD_W-1:0]  dist_full;
  logic signed [grc_pkg::POS_W-1:0]   dist_w;
  logic                               pick_v;

  // Divider hookup
  logic                               div_start, div_done;
  logic [grc_pkg::DEN_W-1:0]          div_num, div_den;
  logic [grc_pkg::DIV_W-1:0]          div_dividend, div_quo;
  logic signed [grc_pkg::TAN_W-1:0]   ratio_mag;

  // Map access
  logic signed [grc_pkg::POS_W-1:0]   mx_f, my_f;
  logic                               in_map, rd_ok;
  logic [MpW-1:0]                     mp;
  logic [MemAw-1:0]                   rd_addr;
  logic [grc_pkg::CODE_W-1:0]         ram_rdata;
  logic                               ram_we, idx_ok, req_fire;
  logic [MemDepth-1:0]                cell_vld_q;
  logic                               vld_rd_q;
  logic                               cell_hit;

  assign req_i.ready = (state_q == S_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;

  assign px_s = grc_pkg::POS_W'(px_q);
  assign py_s = grc_pkg::POS_W'(py_q);
  assign bx   = px_s & ~(CellSpan - 1'b1);
  assign by   = py_s & ~(CellSpan - 1'b1);

  // Fold the angle onto the quarter wave
  always_comb begin
    a_cur = which_q ? ang_q + grc_pkg::ANG_W'(1024) : ang_q;
    qarg  = a_cur[10] ? 11'd1024 - {1'b0, a_cur[9:0]} : {1'b0, a_cur[9:0]};
    t_val = {qarg, 6'b0};
  end

  // Finish the polynomial: round to Q14 and clamp
  always_comb begin
    pfin = ((prod_q >>> 16) + 64'sd32) >>> 6;
    if (pfin < 0) trig_mag = '0;
    else if (pfin > grc_pkg::PROD_W'(grc_pkg::TRIG_ONE))
      trig_mag = grc_pkg::TRIG_W'(grc_pkg::TRIG_ONE);
    else trig_mag = pfin[grc_pkg::TRIG_W-1:0];
  end

  always_comb begin
    sin_abs = sin_q[grc_pkg::TRIG_W-1] ? -sin_q : sin_q;
    cos_abs = cos_q[grc_pkg::TRIG_W-1] ? -cos_q : cos_q;
    c_pos   = cos_q > grc_pkg::TRIG_W'(grc_pkg::NEAR_ZERO);
    c_neg   = cos_q < -grc_pkg::TRIG_W'(grc_pkg::NEAR_ZERO);
    s_pos   = sin_q > grc_pkg::TRIG_W'(grc_pkg::NEAR_ZERO);
    s_neg   = sin_q < -grc_pkg::TRIG_W'(grc_pkg::NEAR_ZERO);
  end

  // Operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_SQ_ISSUE: begin
        mul_a = grc_pkg::POS_W'(t_val);
        mul_b = grc_pkg::MB_W'(t_val);
      end
      S_PL_ISSUE: begin
        mul_a = grc_pkg::POS_W'(p_q);
        mul_b = grc_pkg::MB_W'(t2_q);
      end
      S_PT_ISSUE: begin
        mul_a = grc_pkg::POS_W'(p_q);
        mul_b = grc_pkg::MB_W'(t_val);
      end
      S_WM1: begin
        mul_a = dir_q ? py_s - ry_q : px_s - rx_q;
        mul_b = dir_q ? ct_q : tn_q;
      end
      S_WM2: begin
        mul_a = dir_q ? -yo_q : -xo_q;
        mul_b = dir_q ? ct_q : tn_q;
      end
      S_D1: begin
        mul_a = rx_q - px_s;
        mul_b = grc_pkg::MB_W'(cos_q);
      end
      S_D2: begin
        mul_a = ry_q - py_s;
        mul_b = grc_pkg::MB_W'(sin_q);
      end
      default: ;
    endcase
  end

  assign prod_d = mul_a * mul_b;

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  // Divider operands: tan in S_DIV_T, cot in S_DIV_C
  always_comb begin
    div_start    = 1'b0;
    div_num      = sin_abs[grc_pkg::DEN_W-1:0];
    div_den      = cos_abs[grc_pkg::DEN_W-1:0];
    if (state_q == S_DIV_T) begin
      div_start = c_pos || c_neg;
    end else if (state_q == S_DIV_C) begin
      div_start = s_pos || s_neg;
      div_num   = cos_abs[grc_pkg::DEN_W-1:0];
      div_den   = sin_abs[grc_pkg::DEN_W-1:0];
    end
    div_dividend = {div_num, grc_pkg::TAN_FRAC'(0)} + grc_pkg::DIV_W'(div_den >> 1);
    ratio_mag    = grc_pkg::TAN_W'(div_quo[grc_pkg::TAN_W-2:0]);
  end

  grc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_den),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // Map cell under the current walk point
  always_comb begin
    mx_f    = rx_q >>> CellW;
    my_f    = ry_q >>> CellW;
    in_map  = (mx_f >= 0) && (mx_f < grc_pkg::POS_W'(MAP_SIDE)) &&
              (my_f >= 0) && (my_f < grc_pkg::POS_W'(MAP_SIDE));
    mp      = MpW'(my_f[SideW-1:0]) * MpW'(MAP_SIDE) + MpW'(mx_f[SideW-1:0]);
    rd_ok   = in_map && (mp != '0) && (mp < MpW'(MemDepth));
    rd_addr = mp[MemAw-1:0];
  end

  assign idx_ok = 32'(req_i.cell_index) < NCells;
  assign ram_we = req_fire && (req_i.req_type == grc_pkg::REQ_WRITE) && idx_ok;

  grc_ram #(
    .WIDTH (grc_pkg::CODE_W),
    .DEPTH (MemDepth)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (req_i.cell_index[MemAw-1:0]),
    .wdata_i (req_i.cell_code),
    .raddr_i (rd_addr),
    .rdata_o (ram_rdata)
  );

  // Per-cell written flags; an unwritten cell reads as empty
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_vld_q <= '0;
      vld_rd_q   <= 1'b0;
    end else begin
      if (ram_we) begin
        cell_vld_q[req_i.cell_index[MemAw-1:0]] <= 1'b1;
      end
      vld_rd_q <= cell_vld_q[rd_addr];
    end
  end

  assign cell_hit = vld_rd_q && (ram_rdata != '0);

  // Projected distance from the two products
  always_comb begin
    dist_full = (d1_q - prod_q) >>> grc_pkg::TRIG_FRAC;
    dist_w    = dist_full[grc_pkg::POS_W-1:0];
    pick_v    = vhit_q && (!hhit_q || (vdist_q < hdist_q));
  end

  // Drop the result once it is transferred, load a new one from S_OUT
  always_comb begin
    out_vld_d = out_vld_q;
    if (out_vld_q && res_o.ready) out_vld_d = 1'b0;
    if ((state_q == S_OUT) && (!out_vld_q || res_o.ready)) out_vld_d = 1'b1;
  end

  // Sequencer and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      px_q        <= '0;
      py_q        <= '0;
      ang_q       <= '0;
      which_q     <= 1'b0;
      k_q         <= '0;
      t2_q        <= '0;
      p_q         <= '0;
      sin_q       <= '0;
      cos_q       <= '0;
      tn_q        <= '0;
      ct_q        <= '0;
      dir_q       <= 1'b0;
      rx_q        <= '0;
      ry_q        <= '0;
      xo_q        <= '0;
      yo_q        <= '0;
      step_q      <= '0;
      d1_q        <= '0;
      code_q      <= '0;
      vhit_q      <= 1'b0;
      hhit_q      <= 1'b0;
      vcode_q     <= '0;
      hcode_q     <= '0;
      vx_q        <= '0;
      vy_q        <= '0;
      vdist_q     <= '0;
      hx_q        <= '0;
      hy_q        <= '0;
      hdist_q     <= '0;
      out_vld_q   <= 1'b0;
      out_dist_q  <= '0;
      out_x_q     <= '0;
      out_y_q     <= '0;
      out_wall_q  <= '0;
      out_vside_q <= 1'b0;
      out_nohit_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
      case (state_q)
        S_IDLE: begin
          if (req_fire && (req_i.req_type == grc_pkg::REQ_CAST)) begin
            px_q    <= req_i.player_x;
            py_q    <= req_i.player_y;
            ang_q   <= req_i.ray_angle;
            which_q <= 1'b0;
            state_q <= S_SQ_ISSUE;
          end
        end
        S_SQ_ISSUE: state_q <= S_SQ_TAKE;
        S_SQ_TAKE: begin
          t2_q    <= prod_q[32:16];
          p_q     <= grc_pkg::POLY_SEED;
          k_q     <= '0;
          state_q <= S_PL_ISSUE;
        end
        S_PL_ISSUE: state_q <= S_PL_TAKE;
        S_PL_TAKE: begin
          p_q <= grc_pkg::poly_coef(k_q) + grc_pkg::POLY_W'(prod_q >>> 16);
          k_q <= k_q + 1'b1;
          state_q <= (k_q == 2'd3) ? S_PT_ISSUE : S_PL_ISSUE;
        end
        S_PT_ISSUE: state_q <= S_PT_TAKE;
        S_PT_TAKE: begin
          if (!which_q) begin
            sin_q   <= a_cur[11] ? -trig_mag : trig_mag;
            which_q <= 1'b1;
            state_q <= S_SQ_ISSUE;
          end else begin
            cos_q   <= a_cur[11] ? -trig_mag : trig_mag;
            state_q <= S_DIV_T;
          end
        end
        S_DIV_T: begin
          tn_q    <= '0;
          state_q <= div_start ? S_DIV_T_WAIT : S_DIV_C;
        end
        S_DIV_T_WAIT: begin
          if (div_done) begin
            tn_q    <= (sin_q[grc_pkg::TRIG_W-1] != cos_q[grc_pkg::TRIG_W-1]) ?
                       -ratio_mag : ratio_mag;
            state_q <= S_DIV_C;
          end
        end
        S_DIV_C: begin
          ct_q    <= '0;
          dir_q   <= 1'b0;
          state_q <= div_start ? S_DIV_C_WAIT : S_WINIT;
        end
        S_DIV_C_WAIT: begin
          if (div_done) begin
            ct_q    <= (sin_q[grc_pkg::TRIG_W-1] != cos_q[grc_pkg::TRIG_W-1]) ?
                       -ratio_mag : ratio_mag;
            state_q <= S_WINIT;
          end
        end
        S_WINIT: begin
          step_q <= '0;
          if (!dir_q) begin
            vhit_q <= 1'b0;
            ry_q   <= py_s;
            if (c_pos) begin
              rx_q    <= bx + CellSpan;
              xo_q    <= CellSpan;
              state_q <= S_WM1;
            end else if (c_neg) begin
              rx_q    <= bx - 1'b1;
              xo_q    <= -CellSpan;
              state_q <= S_WM1;
            end else begin
              rx_q    <= px_s;
              state_q <= S_WDONE;
            end
          end else begin
            hhit_q <= 1'b0;
            rx_q   <= px_s;
            if (s_pos) begin
              ry_q    <= by - 1'b1;
              yo_q    <= -CellSpan;
              state_q <= S_WM1;
            end else if (s_neg) begin
              ry_q    <= by + CellSpan;
              yo_q    <= CellSpan;
              state_q <= S_WM1;
            end else begin
              ry_q    <= py_s;
              state_q <= S_WDONE;
            end
          end
        end
        S_WM1: state_q <= S_WM1T;
        S_WM1T: begin
          if (dir_q) rx_q <= px_s + grc_pkg::POS_W'(prod_q >>> grc_pkg::TAN_FRAC);
          else       ry_q <= py_s + grc_pkg::POS_W'(prod_q >>> grc_pkg::TAN_FRAC);
          state_q <= S_WM2;
        end
        S_WM2: state_q <= S_WM2T;
        S_WM2T: begin
          if (dir_q) xo_q <= grc_pkg::POS_W'(prod_q >>> grc_pkg::TAN_FRAC);
          else       yo_q <= grc_pkg::POS_W'(prod_q >>> grc_pkg::TAN_FRAC);
          state_q <= S_WALK;
        end
        S_WALK: begin
          if (step_q == StepW'(MAX_STEPS)) begin
            state_q <= S_WDONE;
          end else if (rd_ok) begin
            state_q <= S_WREAD;
          end else begin
            rx_q   <= rx_q + xo_q;
            ry_q   <= ry_q + yo_q;
            step_q <= step_q + 1'b1;
          end
        end
        S_WREAD: begin
          if (cell_hit) begin
            code_q  <= ram_rdata;
            state_q <= S_D1;
          end else begin
            rx_q    <= rx_q + xo_q;
            ry_q    <= ry_q + yo_q;
            step_q  <= step_q + 1'b1;
            state_q <= S_WALK;
          end
        end
        S_D1: state_q <= S_D1T;
        S_D1T: begin
          d1_q    <= prod_q;
          state_q <= S_D2;
        end
        S_D2: state_q <= S_D2T;
        S_D2T: begin
          if (!dir_q) begin
            vhit_q  <= 1'b1;
            vcode_q <= code_q;
            vx_q    <= rx_q;
            vy_q    <= ry_q;
            vdist_q <= dist_w;
          end else begin
            hhit_q  <= 1'b1;
            hcode_q <= code_q;
            hx_q    <= rx_q;
            hy_q    <= ry_q;
            hdist_q <= dist_w;
          end
          state_q <= S_WDONE;
        end
        S_WDONE: begin
          if (!dir_q) begin
            dir_q   <= 1'b1;
            state_q <= S_WINIT;
          end else begin
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          // Hold until the output register is free
          if (!out_vld_q || res_o.ready) begin
            if (pick_v) begin
              out_dist_q  <= grc_pkg::sat_dist(vdist_q);
              out_x_q     <= grc_pkg::sat_coord(vx_q);
              out_y_q     <= grc_pkg::sat_coord(vy_q);
              out_wall_q  <= vcode_q - 1'b1;
              out_vside_q <= 1'b1;
              out_nohit_q <= 1'b0;
            end else if (hhit_q) begin
              out_dist_q  <= grc_pkg::sat_dist(hdist_q);
              out_x_q     <= grc_pkg::sat_coord(hx_q);
              out_y_q     <= grc_pkg::sat_coord(hy_q);
              out_wall_q  <= hcode_q - 1'b1;
              out_vside_q <= 1'b0;
              out_nohit_q <= 1'b0;
            end else begin
              out_dist_q  <= grc_pkg::DIST_W'(grc_pkg::DIST_MAX);
              out_x_q     <= '0;
              out_y_q     <= '0;
              out_wall_q  <= '0;
              out_vside_q <= 1'b0;
              out_nohit_q <= 1'b1;
            end
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign res_o.valid         = out_vld_q;
  assign res_o.hit_distance  = out_dist_q;
  assign res_o.hit_x         = out_x_q;
  assign res_o.hit_y         = out_y_q;
  assign res_o.wall_type     = out_wall_q;
  assign res_o.vertical_side = out_vside_q;
  assign res_o.no_hit        = out_nohit_q;

endmodule

[src/grc_chk.sv]
// Port-level checker for the grid ray caster, bound to the top level.
module grc_chk (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        req_valid_i,
  input logic                        req_ready_i,
  input logic                        req_type_i,
  input logic                        res_valid_i,
  input logic                        res_ready_i,
  input logic [grc_pkg::DIST_W-1:0]  hit_distance_i,
  input logic [grc_pkg::CODE_W-1:0]  wall_type_i,
  input logic                        vertical_side_i,
  input logic                        no_hit_i
);

  // A miss carries the fixed miss payload
  a_miss_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_i && no_hit_i) |->
      (hit_distance_i == grc_pkg::DIST_W'(grc_pkg::DIST_MAX)) && (wall_type_i == '0) &&
      !vertical_side_i)
    else $error("miss result with nonzero payload");

  // A stalled result stays put
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_i && !res_ready_i) |=>
      res_valid_i && $stable(hit_distance_i) && $stable(no_hit_i))
    else $error("stalled result changed");

  // A map write never produces a result
  a_write_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid_i && req_ready_i && (req_type_i == grc_pkg::REQ_WRITE) && !res_valid_i) |=>
      !res_valid_i)
    else $error("result appeared after a map write");

  // A new result only comes out of a cast in progress
  a_res_from_cast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_valid_i) |-> $past(!req_ready_i))
    else $error("result appeared while idle");

endmodule

bind grid_ray_cast grc_chk u_grc_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .req_valid_i     (req_i.valid),
  .req_ready_i     (req_i.ready),
  .req_type_i      (req_i.req_type),
  .res_valid_i     (res_o.valid),
  .res_ready_i     (res_o.ready),
  .hit_distance_i  (res_o.hit_distance),
  .wall_type_i     (res_o.wall_type),
  .vertical_side_i (res_o.vertical_side),
  .no_hit_i        (res_o.no_hit)
);

[dv/tb_grid_ray_cast.sv]
// Testbench for the grid ray caster: map writes and casts checked against a local predictor.
module tb_grid_ray_cast;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SIDE   = grc_pkg::MAP_SIDE_DEF;
  localparam int STEPS  = grc_pkg::MAX_STEPS_DEF;
  localparam int CSHIFT = grc_pkg::CELL_SHIFT_DEF;
  localparam int SH     = grc_pkg::FRAC_BITS + CSHIFT;
  localparam longint CYCLE_LIMIT = 2000000;

  typedef struct packed {
    logic [grc_pkg::DIST_W-1:0]         distance;
    logic signed [grc_pkg::COORD_W-1:0] hx;
    logic signed [grc_pkg::COORD_W-1:0] hy;
    logic [grc_pkg::CODE_W-1:0]         wall;
    logic                               vside;
    logic                               miss;
  } hit_t;

  typedef struct {
    bit     hit;
    int     code;
    longint x, y, d;
  } trace_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always #5 clk_i = ~clk_i;

  grc_req_if req_i ();
  grc_res_if res_o ();

  grid_ray_cast dut (.clk_i(clk_i), .rst_ni(rst_ni), .req_i(req_i.sink), .res_o(res_o.source));

  logic [grc_pkg::CODE_W-1:0] cells_q [SIDE*SIDE];
  hit_t   hits_q [$];
  longint cycles = 0;
  int     errors = 0;
  bit     bursty = 1'b1;

  // Floor shift for signed values.
  function automatic longint fsr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint qsine(longint r);
    longint t, t2, p;
    t  = r * 64;
    t2 = (t * t) >> 16;
    p  = 168;
    p  = -4909   + fsr(p * t2, 16);
    p  = 83564   + fsr(p * t2, 16);
    p  = -677343 + fsr(p * t2, 16);
    p  = 1647099 + fsr(p * t2, 16);
    p  = fsr(fsr(p * t, 16) + 32, 6);
    if (p < 0) p = 0;
    if (p > grc_pkg::TRIG_ONE) p = grc_pkg::TRIG_ONE;
    return p;
  endfunction

  function automatic longint sin_q14(int a);
    int q, r;
    longint v;
    a = a & 4095;
    q = a >> 10;
    r = a & 1023;
    v = q[0] ? qsine(1024 - r) : qsine(r);
    return q >= 2 ? -v : v;
  endfunction

  function automatic longint ratio12(longint num, longint den);
    longint n, d, m;
    if (den == 0) return 0;
    n = num < 0 ? -num : num;
    d = den < 0 ? -den : den;
    m = (n * 4096 + d / 2) / d;
    return ((num < 0) != (den < 0)) ? -m : m;
  endfunction

  function automatic trace_t trace_line(bit act, longint rx, longint ry, longint xo,
                                        longint yo, longint px, longint py,
                                        longint c, longint s);
    trace_t w;
    longint mx, my, mp;
    w = '{0, 0, 0, 0, 0};
    if (!act) return w;
    for (int i = 0; i < STEPS; i++) begin
      mx = fsr(rx, SH);
      my = fsr(ry, SH);
      if (mx >= 0 && mx < SIDE && my >= 0 && my < SIDE) begin
        mp = my * SIDE + mx;
        if (mp > 0 && cells_q[mp] != 0) begin
          w.hit = 1; w.code = cells_q[mp]; w.x = rx; w.y = ry;
          w.d = fsr(c * (rx - px) - s * (ry - py), 14);
          return w;
        end
      end
      rx += xo; ry += yo;
    end
    return w;
  endfunction

  function automatic longint clampl(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic hit_t cast_ray(longint px, longint py, int ang);
    longint s, c, tn, ct, cw, bx, by, rx, ry, xo, yo;
    bit act;
    trace_t v, h, p;
    hit_t r;
    s  = sin_q14(ang);
    c  = sin_q14(ang + 1024);
    tn = ratio12(s, c);
    ct = ratio12(c, s);
    cw = 64'd1 << SH;
    bx = (px >> SH) << SH;
    by = (py >> SH) << SH;
    // walk across vertical grid lines
    act = 1; rx = px; ry = py; xo = 0; yo = 0;
    if (c > grc_pkg::NEAR_ZERO) begin rx = bx + cw; xo = cw; end
    else if (c < -grc_pkg::NEAR_ZERO) begin rx = bx - 1; xo = -cw; end
    else act = 0;
    if (act) begin ry = py + fsr((px - rx) * tn, 12); yo = fsr(-(xo * tn), 12); end
    v = trace_line(act, rx, ry, xo, yo, px, py, c, s);
    // walk across horizontal grid lines
    act = 1; rx = px; ry = py; xo = 0; yo = 0;
    if (s > grc_pkg::NEAR_ZERO) begin ry = by - 1; yo = -cw; end
    else if (s < -grc_pkg::NEAR_ZERO) begin ry = by + cw; yo = cw; end
    else act = 0;
    if (act) begin rx = px + fsr((py - ry) * ct, 12); xo = fsr(-(yo * ct), 12); end
    h = trace_line(act, rx, ry, xo, yo, px, py, c, s);
    if (!v.hit && !h.hit) begin
      r.distance = grc_pkg::DIST_W'(grc_pkg::DIST_MAX); r.hx = '0; r.hy = '0; r.wall = '0;
      r.vside = 0; r.miss = 1;
      return r;
    end
    r.vside    = v.hit && (!h.hit || v.d < h.d);
    p          = r.vside ? v : h;
    r.distance = grc_pkg::DIST_W'(clampl(p.d, 0, grc_pkg::DIST_MAX));
    r.hx       = grc_pkg::COORD_W'(clampl(p.x, grc_pkg::COORD_MIN, grc_pkg::COORD_MAX));
    r.hy       = grc_pkg::COORD_W'(clampl(p.y, grc_pkg::COORD_MIN, grc_pkg::COORD_MAX));
    r.wall     = grc_pkg::CODE_W'(p.code - 1);
    r.miss     = 0;
    return r;
  endfunction

  // Drive one request, predict on transfer; valid stays high into the next request.
  task automatic send_req(logic kind, int idx, int code, int px, int py, int ang);
    if (bursty && $urandom_range(0, 3) == 0) begin
      req_i.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    req_i.valid      <= 1'b1;
    req_i.req_type   <= kind;
    req_i.cell_index <= grc_pkg::CELL_IDX_W'(idx);
    req_i.cell_code  <= grc_pkg::CODE_W'(code);
    req_i.player_x   <= grc_pkg::PX_W'(px);
    req_i.player_y   <= grc_pkg::PX_W'(py);
    req_i.ray_angle  <= grc_pkg::ANG_W'(ang);
    do @(posedge clk_i); while (!req_i.ready);
    if (kind == grc_pkg::REQ_WRITE) cells_q[idx] = grc_pkg::CODE_W'(code);
    else hits_q.push_back(cast_ray(px, py, ang));
  endtask

  task automatic write_cell(int idx, int code);
    send_req(grc_pkg::REQ_WRITE, idx, code, $urandom_range(0, 131071),
             $urandom_range(0, 131071), $urandom_range(0, 4095));
  endtask

  task automatic cast(int px, int py, int ang);
    send_req(grc_pkg::REQ_CAST, $urandom_range(0, 63), $urandom_range(0, 7), px, py, ang);
  endtask

  function automatic int in_map();
    return $urandom_range(0, SIDE * 64 * 256 - 1);
  endfunction

  // Empty map, axis angles, field extremes, cell zero and map border.
  task automatic test_directed();
    cast(0, 0, 0);
    cast(131071, 131071, 4095);
    cast(100 * 256, 100 * 256, 1024);
    write_cell(0, 7);
    write_cell(9, 1);
    write_cell(63, 7);
    write_cell(7, 3);
    cast(10, 10, 3500);
    cast(96 * 256, 96 * 256, 0);
    cast(96 * 256, 96 * 256, 1024);
    cast(96 * 256, 96 * 256, 2048);
    cast(96 * 256, 96 * 256, 3072);
    cast(96 * 256, 96 * 256, 1);
    cast(96 * 256, 96 * 256, 512);
    cast(96 * 256, 96 * 256, 3584);
    cast(500 * 256, 500 * 256, 2560);
    cast(131071, 0, 2048);
    cast(0, 131071, 1024);
    cast(80 * 256, 140 * 256, 1500);
    write_cell(9, 0);
    cast(96 * 256, 96 * 256, 2560);
  endtask

  // Mostly casts from inside the map over a densely written map.
  task automatic test_random(int n);
    int r;
    bursty = 1'b1;
    for (int i = 0; i < n; i++) begin
      if (i % 400 == 200) bursty = 1'b0;
      if (i % 400 == 300) bursty = 1'b1;
      r = $urandom_range(0, 9);
      if (r < 3) write_cell($urandom_range(0, 63), $urandom_range(0, 7));
      else if (r < 8) cast(in_map(), in_map(), $urandom_range(0, 4095));
      else if (r < 9) cast($urandom_range(0, 131071), $urandom_range(0, 131071),
                            $urandom_range(0, 4095));
      else cast(in_map(), in_map(), ($urandom_range(0, 3) * 1024 +
                $urandom_range(0, 4) - 2) & 4095);
    end
  endtask

  // Receiver stall pattern.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_o.ready <= 1'b0;
    end else begin
      res_o.ready <= (cycles % 512 < 128) ? 1'b1 : ($urandom_range(0, 2) != 0);
    end
  end

  // Check each result transfer.
  always @(posedge clk_i) begin
    hit_t got, want;
    cycles <= cycles + 1;
    if (rst_ni && res_o.valid && res_o.ready) begin
      got = '{res_o.hit_distance, res_o.hit_x, res_o.hit_y, res_o.wall_type,
              res_o.vertical_side, res_o.no_hit};
      if (hits_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %p", got);
      end else begin
        want = hits_q.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10) $display("mismatch: expected %p got %p", want, got);
        end
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_grid_ray_cast failed");
      $finish;
    end
  end

  initial begin
    req_i.valid = 1'b0; req_i.req_type = grc_pkg::REQ_WRITE; req_i.cell_index = '0;
    req_i.cell_code = '0; req_i.player_x = '0; req_i.player_y = '0; req_i.ray_angle = '0;
    foreach (cells_q[i]) cells_q[i] = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(1600);
    req_i.valid <= 1'b0;
    while (hits_q.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (errors == 0) $display("tb_grid_ray_cast passed");
    else $display("tb_grid_ray_cast failed");
    $finish;
  end

endmodule
